// File: hdl/pcr_pkg.sv
// Shared widths, types and helper functions for the particle contact resolver.
package pcr_pkg;

  // Component format: signed fixed point with 12 fraction bits
  localparam int CW     = 21;
  localparam int VW     = 3 * CW;
  localparam int FRAC   = 12;
  localparam int IM_W   = 16;
  localparam int TOT_W  = IM_W + 1;
  localparam int REST_W = 13;
  localparam int ST_W   = 16;
  localparam int PEN_W  = 21;
  localparam int QP_W   = PEN_W - 1;

  // Datapath widths
  localparam int PROD_W = 2 * CW + 1;        // (va - vb) * n
  localparam int SEP_W  = PROD_W + 2;        // sum of three products
  localparam int WIDE_W = 64;                // restitution / acceleration terms
  localparam int DEL_W  = 2 * CW - 8;        // velocity change, always >= 0
  localparam int QW     = DEL_W;             // quotient bits
  localparam int DVD_W  = DEL_W + IM_W;      // dividend
  localparam int MV_W   = CW + QW + 1;       // n * velocity share
  localparam int MP_W   = CW + QP_W + 1;     // n * penetration share
  localparam int RV_W   = MV_W - FRAC;
  localparam int RP_W   = MP_W - FRAC;
  localparam int SAT_W  = RV_W + 2;

  // Pipeline depth: nine front stages, one per quotient bit, three back stages
  localparam int DIV_N  = QW;
  localparam int NST    = 9 + DIV_N + 3;
  localparam int SIDE_N = NST - 1;
  localparam int CTL_N  = 9;

  localparam logic [ST_W-1:0] STEP_TIME_RST = ST_W'(68);

  // Register byte address
  localparam logic [1:0] ADDR_STEP_TIME = 2'd0;

  typedef logic signed [CW-1:0] comp_t;
  typedef logic [VW-1:0]        vec_t;

  // Operands carried alongside the arithmetic
  typedef struct packed {
    vec_t va;
    vec_t vb;
    vec_t pa;
    vec_t pb;
    vec_t nrm;
    logic act_v;
    logic act_p;
  } side_t;

  // Scalar operands of the front stages
  typedef struct packed {
    logic [IM_W-1:0]   ima;
    logic [IM_W-1:0]   imb;
    logic [TOT_W-1:0]  tot;
    logic [REST_W-1:0] rest;
    logic [QP_W-1:0]   pen_pos;
  } ctl_t;

  typedef struct packed {
    vec_t nva;
    vec_t nvb;
    vec_t npa;
    vec_t npb;
    vec_t ma;
    vec_t mb;
  } res_t;

  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

  // Extract component k of a packed vector
  function automatic comp_t get_c(input vec_t v, input int unsigned k);
    return comp_t'(v[k*CW +: CW]);
  endfunction

  // Saturate to the component range
  function automatic comp_t sat_c(input logic signed [SAT_W-1:0] v);
    comp_t r;
    if (v > SAT_HI) begin
      r = comp_t'(SAT_HI);
    end else if (v < SAT_LO) begin
      r = comp_t'(SAT_LO);
    end else begin
      r = comp_t'(v);
    end
    return r;
  endfunction

endpackage

// File: hdl/pcr_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module pcr_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [pcr_pkg::DVD_W-1:0]  dvd_i,
  input  logic [pcr_pkg::TOT_W-1:0]  dvs_i,
  output logic [pcr_pkg::QW-1:0]     quo_o
);
  import pcr_pkg::*;

  logic [TOT_W-1:0] rem_r   [DIV_N];
  logic [QW-1:0]    low_r   [DIV_N];
  logic [TOT_W-1:0] dvs_r   [DIV_N];
  logic [QW-1:0]    q_r     [DIV_N];
  logic [TOT_W-1:0] rem_nxt [DIV_N];
  logic [QW-1:0]    low_nxt [DIV_N];
  logic [TOT_W-1:0] dvs_nxt [DIV_N];
  logic [QW-1:0]    q_nxt   [DIV_N];

  // One compare and subtract per stage
  always_comb begin
    logic [TOT_W-1:0] rem_in;
    logic [QW-1:0]    low_in;
    logic [TOT_W-1:0] dvs_in;
    logic [QW-1:0]    q_in;
    logic [TOT_W:0]   t;
    logic             ge;
    for (int j = 0; j < DIV_N; j++) begin
      if (j == 0) begin
        rem_in = TOT_W'(dvd_i[DVD_W-1:QW]);
        low_in = dvd_i[QW-1:0];
        dvs_in = dvs_i;
        q_in   = '0;
      end else begin
        rem_in = rem_r[j-1];
        low_in = low_r[j-1];
        dvs_in = dvs_r[j-1];
        q_in   = q_r[j-1];
      end
      t  = {rem_in, low_in[QW-1]};
      ge = (t >= {1'b0, dvs_in});
      rem_nxt[j] = ge ? TOT_W'(t - {1'b0, dvs_in}) : TOT_W'(t);
      low_nxt[j] = {low_in[QW-2:0], 1'b0};
      dvs_nxt[j] = dvs_in;
      q_nxt[j]   = {q_in[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < DIV_N; j++) begin
        rem_r[j] <= rem_nxt[j];
        low_r[j] <= low_nxt[j];
        dvs_r[j] <= dvs_nxt[j];
        q_r[j]   <= q_nxt[j];
      end
    end
  end

  assign quo_o = q_r[DIV_N-1];

endmodule

// File: hdl/particle_contact_resolver_core.sv
// Particle contact resolver top level: front arithmetic, dividers, back stages, output buffer.
//
// Usage: one contact is accepted per in_valid/in_ready transfer; one result per
// contact leaves on the out_valid/out_ready channel, in order. Vectors are packed
// x,y,z signed components with 12 fraction bits; results saturate.
// Pipeline: a result passes 46 pipeline registers, the first loaded at its input
// transfer edge, then the output register.
// Throughput: one contact per cycle while in_ready is high; the depth is set by
// the four shared-divisor dividers, one quotient bit per stage.
// The whole pipeline advances together; a two-entry output buffer (output
// register plus skid register) lets one more result land while the receiver
// stalls, and in_ready drops only while the skid register is full.
// Reset (rst_n low, synchronous) empties the pipeline and output buffer and sets
// step_time to 68. step_time is written over the APB port (byte address 0) and
// should change only while no contact is in flight. pready is always high.
module particle_contact_resolver_core (
  input  logic                       clk,
  input  logic                       rst_n,
  // Configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [1:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // Input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pcr_pkg::VW-1:0]     in_vel_a_xyz,
  input  logic [pcr_pkg::VW-1:0]     in_vel_b_xyz,
  input  logic [pcr_pkg::VW-1:0]     in_acc_a_xyz,
  input  logic [pcr_pkg::VW-1:0]     in_acc_b_xyz,
  input  logic [pcr_pkg::VW-1:0]     in_pos_a_xyz,
  input  logic [pcr_pkg::VW-1:0]     in_pos_b_xyz,
  input  logic [pcr_pkg::VW-1:0]     in_contact_normal_xyz,
  input  logic [pcr_pkg::IM_W-1:0]   in_inv_mass_a,
  input  logic [pcr_pkg::IM_W-1:0]   in_inv_mass_b,
  input  logic signed [pcr_pkg::PEN_W-1:0] in_penetration_depth,
  input  logic [pcr_pkg::REST_W-1:0] in_restitution_coef,
  // Result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pcr_pkg::VW-1:0]     out_new_vel_a_xyz,
  output logic [pcr_pkg::VW-1:0]     out_new_vel_b_xyz,
  output logic [pcr_pkg::VW-1:0]     out_new_pos_a_xyz,
  output logic [pcr_pkg::VW-1:0]     out_new_pos_b_xyz,
  output logic [pcr_pkg::VW-1:0]     out_move_a_xyz,
  output logic [pcr_pkg::VW-1:0]     out_move_b_xyz
);
  import pcr_pkg::*;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  // ---------------------------------------------------------------- config
  logic [ST_W-1:0] step_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_time_r <= STEP_TIME_RST;
    end else if (psel && penable && pwrite && (paddr == ADDR_STEP_TIME)) begin
      step_time_r <= pwdata[ST_W-1:0];
    end
  end

  assign prdata = {{(32-ST_W){1'b0}}, step_time_r};
  assign pready = 1'b1;

  // ---------------------------------------------------------------- control
  logic           en;
  logic [NST-1:0] vld_r;
  logic           out_valid_r;
  logic           skid_valid_r;
  res_t           res_r;
  res_t           out_r;
  res_t           skid_r;

  assign en       = !skid_valid_r;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // ---------------------------------------------------------------- operand chains
  side_t side_r [SIDE_N];
  ctl_t  ctl_r  [CTL_N];

  // ---------------------------------------------------------------- stage 1: products
  prod_t dvp_c [3];
  prod_t dap_c [3];
  prod_t dvp_r [3];
  prod_t dap_r [3];
  ctl_t  ctl_c;

  always_comb begin
    logic signed [CW:0] dv;
    logic signed [CW:0] da;
    comp_t              nk;
    for (int k = 0; k < 3; k++) begin
      nk = get_c(in_contact_normal_xyz, k);
      dv = (CW+1)'(get_c(in_vel_a_xyz, k)) - (CW+1)'(get_c(in_vel_b_xyz, k));
      da = (CW+1)'(get_c(in_acc_a_xyz, k)) - (CW+1)'(get_c(in_acc_b_xyz, k));
      dvp_c[k] = PROD_W'(dv) * PROD_W'(nk);
      dap_c[k] = PROD_W'(da) * PROD_W'(nk);
    end
    ctl_c.ima     = in_inv_mass_a;
    ctl_c.imb     = in_inv_mass_b;
    ctl_c.tot     = {1'b0, in_inv_mass_a} + {1'b0, in_inv_mass_b};
    ctl_c.rest    = in_restitution_coef;
    ctl_c.pen_pos = (in_penetration_depth > 0) ? in_penetration_depth[QP_W-1:0] : '0;
  end

  // ---------------------------------------------------------------- stages 2..9
  logic signed [SEP_W-1:0] sep2_r, accd2_r;
  wide_t                   nsep3_r, accm3_r;
  logic signed [SEP_W-1:0] sep3_r, sep4_r, sep5_r, sep6_r;
  wide_t                   acs4_r, nsep4_r;
  wide_t                   corr5_r, nsep5_r;
  logic                    neg5_r;
  wide_t                   newsep6_r;
  logic [DEL_W-1:0]        delta7_r;
  logic [DVD_W-1:0]        pva8_r, pvb8_r, ppa8_r, ppb8_r;
  logic [DVD_W-1:0]        dva9_r, dvb9_r, dpa9_r, dpb9_r;

  wide_t            acs_c;
  wide_t            newsep_c;
  logic [DEL_W-1:0] delta_c;
  side_t            side2_c;

  always_comb begin
    wide_t t4;
    wide_t sum6;
    wide_t diff7;
    wide_t t7;
    // round the acceleration term to 12 fraction bits, ties away from zero
    t4    = accm3_r + wide_t'(2048) - wide_t'({1'b0, accm3_r[WIDE_W-1]});
    acs_c = t4 >>> FRAC;
    // add the acceleration correction only when it is negative, clamp at zero
    sum6 = nsep5_r + corr5_r;
    if (neg5_r) begin
      newsep_c = sum6[WIDE_W-1] ? '0 : sum6;
    end else begin
      newsep_c = nsep5_r;
    end
    // velocity change back to 12 fraction bits
    diff7   = newsep6_r - (wide_t'(sep6_r) <<< FRAC);
    t7      = diff7 + (wide_t'(1) <<< (2*FRAC - 1)) - wide_t'({1'b0, diff7[WIDE_W-1]});
    delta_c = DEL_W'(t7 >>> (2*FRAC));
  end

  // closing contact with finite mass: velocities change
  always_comb begin
    side2_c       = side_r[1];
    side2_c.act_v = !(sep2_r > 0) && (ctl_r[1].tot != '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      for (int k = 0; k < 3; k++) begin
        dvp_r[k] <= dvp_c[k];
        dap_r[k] <= dap_c[k];
      end
      // stage 2: dot products
      sep2_r  <= SEP_W'(dvp_r[0]) + SEP_W'(dvp_r[1]) + SEP_W'(dvp_r[2]);
      accd2_r <= SEP_W'(dap_r[0]) + SEP_W'(dap_r[1]) + SEP_W'(dap_r[2]);
      // stage 3: restitution term and acceleration over one frame
      nsep3_r <= -(wide_t'(sep2_r) * wide_t'($signed({1'b0, ctl_r[1].rest})));
      accm3_r <= wide_t'(accd2_r) * wide_t'($signed({1'b0, step_time_r}));
      sep3_r  <= sep2_r;
      // stage 4
      acs4_r  <= acs_c;
      nsep4_r <= nsep3_r;
      sep4_r  <= sep3_r;
      // stage 5
      corr5_r <= acs4_r * wide_t'($signed({1'b0, ctl_r[3].rest}));
      neg5_r  <= acs4_r[WIDE_W-1];
      nsep5_r <= nsep4_r;
      sep5_r  <= sep4_r;
      // stage 6
      newsep6_r <= newsep_c;
      sep6_r    <= sep5_r;
      // stage 7
      delta7_r <= delta_c;
      // stage 8: numerators of the mass shares
      pva8_r <= DVD_W'(delta7_r) * DVD_W'(ctl_r[6].ima);
      pvb8_r <= DVD_W'(delta7_r) * DVD_W'(ctl_r[6].imb);
      ppa8_r <= DVD_W'(ctl_r[6].pen_pos) * DVD_W'(ctl_r[6].ima);
      ppb8_r <= DVD_W'(ctl_r[6].pen_pos) * DVD_W'(ctl_r[6].imb);
      // stage 9: add half the divisor for round to nearest
      dva9_r <= pva8_r + DVD_W'(ctl_r[7].tot >> 1);
      dvb9_r <= pvb8_r + DVD_W'(ctl_r[7].tot >> 1);
      dpa9_r <= ppa8_r + DVD_W'(ctl_r[7].tot >> 1);
      dpb9_r <= ppb8_r + DVD_W'(ctl_r[7].tot >> 1);
      // operand chains
      ctl_r[0] <= ctl_c;
      for (int i = 1; i < CTL_N; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
      side_r[0].va    <= in_vel_a_xyz;
      side_r[0].vb    <= in_vel_b_xyz;
      side_r[0].pa    <= in_pos_a_xyz;
      side_r[0].pb    <= in_pos_b_xyz;
      side_r[0].nrm   <= in_contact_normal_xyz;
      side_r[0].act_v <= 1'b0;
      side_r[0].act_p <= (in_penetration_depth > 0) && (ctl_c.tot != '0);
      for (int i = 1; i < SIDE_N; i++) begin
        side_r[i] <= (i == 2) ? side2_c : side_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- dividers
  logic [QW-1:0] qva, qvb, qpa, qpb;

  pcr_div u_div_va (.clk(clk), .en(en), .dvd_i(dva9_r), .dvs_i(ctl_r[8].tot), .quo_o(qva));
  pcr_div u_div_vb (.clk(clk), .en(en), .dvd_i(dvb9_r), .dvs_i(ctl_r[8].tot), .quo_o(qvb));
  pcr_div u_div_pa (.clk(clk), .en(en), .dvd_i(dpa9_r), .dvs_i(ctl_r[8].tot), .quo_o(qpa));
  pcr_div u_div_pb (.clk(clk), .en(en), .dvd_i(dpb9_r), .dvs_i(ctl_r[8].tot), .quo_o(qpb));

  // ---------------------------------------------------------------- back stages
  logic signed [MV_W-1:0] mva_r [3];
  logic signed [MV_W-1:0] mvb_r [3];
  logic signed [MP_W-1:0] mpa_r [3];
  logic signed [MP_W-1:0] mpb_r [3];
  logic signed [RV_W-1:0] rva_r [3];
  logic signed [RV_W-1:0] rvb_r [3];
  logic signed [RP_W-1:0] rpa_r [3];
  logic signed [RP_W-1:0] rpb_r [3];

  logic signed [MV_W-1:0] mva_c [3];
  logic signed [MV_W-1:0] mvb_c [3];
  logic signed [MP_W-1:0] mpa_c [3];
  logic signed [MP_W-1:0] mpb_c [3];
  logic signed [RV_W-1:0] rva_c [3];
  logic signed [RV_W-1:0] rvb_c [3];
  logic signed [RP_W-1:0] rpa_c [3];
  logic signed [RP_W-1:0] rpb_c [3];
  res_t                   res_c;

  always_comb begin
    logic [QW-1:0]          sa, sb;
    logic [QP_W-1:0]        pa_s, pb_s;
    comp_t                  nk;
    logic signed [MV_W-1:0] tv;
    logic signed [MP_W-1:0] tp;
    // gated shares: zero leaves the item untouched
    sa   = side_r[SIDE_N-3].act_v ? qva : '0;
    sb   = side_r[SIDE_N-3].act_v ? qvb : '0;
    pa_s = side_r[SIDE_N-3].act_p ? qpa[QP_W-1:0] : '0;
    pb_s = side_r[SIDE_N-3].act_p ? qpb[QP_W-1:0] : '0;
    for (int k = 0; k < 3; k++) begin
      nk = get_c(side_r[SIDE_N-3].nrm, k);
      mva_c[k] = MV_W'(nk) * $signed({1'b0, sa});
      mvb_c[k] = MV_W'(nk) * $signed({1'b0, sb});
      mpa_c[k] = MP_W'(nk) * $signed({1'b0, pa_s});
      mpb_c[k] = MP_W'(nk) * $signed({1'b0, pb_s});
      // round to 12 fraction bits, ties away from zero
      tv = mva_r[k] + MV_W'(2048) - MV_W'({1'b0, mva_r[k][MV_W-1]});
      rva_c[k] = RV_W'(tv >>> FRAC);
      tv = mvb_r[k] + MV_W'(2048) - MV_W'({1'b0, mvb_r[k][MV_W-1]});
      rvb_c[k] = RV_W'(tv >>> FRAC);
      tp = mpa_r[k] + MP_W'(2048) - MP_W'({1'b0, mpa_r[k][MP_W-1]});
      rpa_c[k] = RP_W'(tp >>> FRAC);
      tp = mpb_r[k] + MP_W'(2048) - MP_W'({1'b0, mpb_r[k][MP_W-1]});
      rpb_c[k] = RP_W'(tp >>> FRAC);
      // apply and saturate
      res_c.nva[k*CW +: CW] = sat_c(SAT_W'(get_c(side_r[SIDE_N-1].va, k)) + SAT_W'(rva_r[k]));
      res_c.nvb[k*CW +: CW] = sat_c(SAT_W'(get_c(side_r[SIDE_N-1].vb, k)) - SAT_W'(rvb_r[k]));
      res_c.npa[k*CW +: CW] = sat_c(SAT_W'(get_c(side_r[SIDE_N-1].pa, k)) + SAT_W'(rpa_r[k]));
      res_c.npb[k*CW +: CW] = sat_c(SAT_W'(get_c(side_r[SIDE_N-1].pb, k)) - SAT_W'(rpb_r[k]));
      res_c.ma[k*CW +: CW]  = sat_c(SAT_W'(rpa_r[k]));
      res_c.mb[k*CW +: CW]  = sat_c(-SAT_W'(rpb_r[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mva_r[k] <= mva_c[k];
        mvb_r[k] <= mvb_c[k];
        mpa_r[k] <= mpa_c[k];
        mpb_r[k] <= mpb_c[k];
        rva_r[k] <= rva_c[k];
        rvb_r[k] <= rvb_c[k];
        rpa_r[k] <= rpa_c[k];
        rpb_r[k] <= rpb_c[k];
      end
      res_r <= res_c;
    end
  end

  // ---------------------------------------------------------------- output buffer
  logic pop;
  assign pop = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (vld_r[NST-1]) begin
      if (out_valid_r && !out_ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (vld_r[NST-1]) begin
      if (out_valid_r && !out_ready) begin
        skid_r <= res_r;
      end else begin
        out_r <= res_r;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_new_vel_a_xyz = out_r.nva;
  assign out_new_vel_b_xyz = out_r.nvb;
  assign out_new_pos_a_xyz = out_r.npa;
  assign out_new_pos_b_xyz = out_r.npb;
  assign out_move_a_xyz    = out_r.ma;
  assign out_move_b_xyz    = out_r.mb;

  // ---------------------------------------------------------------- checks
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !skid_valid_r))
    else $error("output buffer not empty after reset");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while the output register is empty");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NST-1] && !skid_valid_r && out_valid_r && !out_ready) |=> skid_valid_r)
    else $error("result arriving during a stall was not caught in the skid register");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_ready) |=> (out_valid_r && !skid_valid_r))
    else $error("skid register did not drain on a transfer");

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the particle contact resolver core.
module testbench;
  import pcr_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 150;
  localparam int DRAIN_CYCLES   = 60;

  // One contact as driven on the input channel
  typedef struct {
    vec_t              va, vb, aa, ab, pa, pb, nrm;
    logic [IM_W-1:0]   ima, imb;
    logic signed [PEN_W-1:0] pen;
    logic [REST_W-1:0] rest;
  } contact_t;

  // Directed row: contact plus an optional typed-in result
  typedef struct {
    contact_t c;
    bit       has_res;
    res_t     res;
  } contact_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  contact_t drv = '{default: '0};
  logic out_valid;
  logic out_ready = 1'b0;
  vec_t out_nva, out_nvb, out_npa, out_npb, out_ma, out_mb;

  res_t expected_q[$];
  logic [ST_W-1:0] step_time_model = STEP_TIME_RST;
  int fails = 0;
  int idle_cycles = 0;
  int tx_idle_max = 6;
  int rx_idle_max = 6;
  bit long_hold = 1'b0;

  always #5 clk = ~clk;

  particle_contact_resolver_core DUT (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_vel_a_xyz(drv.va), .in_vel_b_xyz(drv.vb),
    .in_acc_a_xyz(drv.aa), .in_acc_b_xyz(drv.ab),
    .in_pos_a_xyz(drv.pa), .in_pos_b_xyz(drv.pb),
    .in_contact_normal_xyz(drv.nrm),
    .in_inv_mass_a(drv.ima), .in_inv_mass_b(drv.imb),
    .in_penetration_depth(drv.pen), .in_restitution_coef(drv.rest),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_new_vel_a_xyz(out_nva), .out_new_vel_b_xyz(out_nvb),
    .out_new_pos_a_xyz(out_npa), .out_new_pos_b_xyz(out_npb),
    .out_move_a_xyz(out_ma), .out_move_b_xyz(out_mb)
  );

  // ---------------- predictor ----------------

  // Drop s fraction bits, nearest, ties away from zero
  function automatic longint round_off(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) << (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  // Weighted share of a nonnegative amount, rounded to nearest
  function automatic longint mass_share(longint x, longint w, longint total);
    return (x * w + total / 2) / total;
  endfunction

  function automatic longint comp_of(vec_t v, int k);
    return longint'($signed(v[k*CW +: CW]));
  endfunction

  function automatic vec_t pack_sat(longint c[3]);
    vec_t r;
    longint hi, v;
    hi = (longint'(1) << (CW - 1)) - 1;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      v = c[k];
      if (v > hi) v = hi;
      if (v < -hi - 1) v = -hi - 1;
      r[k*CW +: CW] = v[CW-1:0];
    end
    return r;
  endfunction

  function automatic res_t resolve_contact(contact_t c, logic [ST_W-1:0] st);
    longint va[3], vb[3], aa[3], ab[3], pa[3], pb[3], n[3];
    longint nva[3], nvb[3], npa[3], npb[3], ma[3], mb[3];
    longint ima, imb, total, pen, rest, sep, accd, newsep, accsep, delta, sa, sb, qa, qb;
    res_t r;
    ima = longint'(c.ima);
    imb = longint'(c.imb);
    total = ima + imb;
    pen = longint'(c.pen);
    rest = longint'(c.rest);
    sep = 0;
    accd = 0;
    for (int k = 0; k < 3; k++) begin
      va[k] = comp_of(c.va, k);  vb[k] = comp_of(c.vb, k);
      aa[k] = comp_of(c.aa, k);  ab[k] = comp_of(c.ab, k);
      pa[k] = comp_of(c.pa, k);  pb[k] = comp_of(c.pb, k);
      n[k]  = comp_of(c.nrm, k);
      nva[k] = va[k]; nvb[k] = vb[k]; npa[k] = pa[k]; npb[k] = pb[k];
      ma[k] = 0; mb[k] = 0;
      sep  += (va[k] - vb[k]) * n[k];
      accd += (aa[k] - ab[k]) * n[k];
    end
    // closing contact: restitution impulse less acceleration build-up
    if (sep <= 0 && total != 0) begin
      newsep = -sep * rest;
      accsep = round_off(accd * longint'(st), FRAC);
      if (accsep < 0) begin
        newsep += rest * accsep;
        if (newsep < 0) newsep = 0;
      end
      delta = round_off(newsep - sep * (longint'(1) << FRAC), 2 * FRAC);
      sa = mass_share(delta, ima, total);
      sb = mass_share(delta, imb, total);
      for (int k = 0; k < 3; k++) begin
        nva[k] = va[k] + round_off(n[k] * sa, FRAC);
        nvb[k] = vb[k] - round_off(n[k] * sb, FRAC);
      end
    end
    // penetration push-out along the normal
    if (pen > 0 && total != 0) begin
      qa = mass_share(pen, ima, total);
      qb = mass_share(pen, imb, total);
      for (int k = 0; k < 3; k++) begin
        ma[k] = round_off(n[k] * qa, FRAC);
        mb[k] = -round_off(n[k] * qb, FRAC);
        npa[k] = pa[k] + ma[k];
        npb[k] = pb[k] + mb[k];
      end
    end
    r.nva = pack_sat(nva); r.nvb = pack_sat(nvb);
    r.npa = pack_sat(npa); r.npb = pack_sat(npb);
    r.ma  = pack_sat(ma);  r.mb  = pack_sat(mb);
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic vec_t vec3(int x, int y, int z);
    vec_t v;
    v = {CW'(z), CW'(y), CW'(x)};
    return v;
  endfunction

  function automatic logic [CW-1:0] rand_comp();
    logic [CW-1:0] r;
    case ($urandom_range(0, 6))
      0: r = {1'b0, {(CW-1){1'b1}}};
      1: r = {1'b1, {(CW-1){1'b0}}};
      2: r = '0;
      3: r = CW'($urandom);
      default: r = CW'($urandom_range(0, 16384) - 8192);
    endcase
    return r;
  endfunction

  function automatic vec_t rand_vec();
    return {rand_comp(), rand_comp(), rand_comp()};
  endfunction

  // Mostly axis or small normals, sometimes arbitrary
  function automatic vec_t rand_normal();
    vec_t v;
    case ($urandom_range(0, 3))
      0: v = vec3(($urandom_range(0, 1) ? 4096 : -4096), 0, 0);
      1: v = vec3(0, 0, ($urandom_range(0, 1) ? 4096 : -4096));
      2: v = vec3($urandom_range(0, 8192) - 4096, $urandom_range(0, 8192) - 4096,
                  $urandom_range(0, 8192) - 4096);
      default: v = rand_vec();
    endcase
    return v;
  endfunction

  function automatic contact_t rand_contact();
    contact_t c;
    bit no_b;
    no_b = ($urandom_range(0, 7) == 0);
    c.va = rand_vec(); c.aa = rand_vec(); c.pa = rand_vec();
    c.vb = no_b ? '0 : rand_vec();
    c.ab = no_b ? '0 : rand_vec();
    c.pb = no_b ? '0 : rand_vec();
    c.nrm = rand_normal();
    case ($urandom_range(0, 5))
      0: c.ima = '0;
      1: c.ima = '1;
      default: c.ima = IM_W'($urandom);
    endcase
    c.imb = no_b ? '0 : (($urandom_range(0, 5) == 0) ? '0 : IM_W'($urandom));
    case ($urandom_range(0, 3))
      0: c.pen = PEN_W'($urandom);
      default: c.pen = PEN_W'($urandom_range(0, 8192));
    endcase
    c.rest = ($urandom_range(0, 7) == 0) ? REST_W'($urandom) : REST_W'($urandom_range(0, 4096));
    return c;
  endfunction

  // ---------------- input driver ----------------

  task automatic send_contact(contact_t c, res_t r);
    int gap;
    gap = $urandom_range(0, tx_idle_max);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    drv = c;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(r);
    @(negedge clk);
  endtask

  task automatic send_predicted(contact_t c);
    send_contact(c, resolve_contact(c, step_time_model));
  endtask

  // Wait for all results, then let the pipeline settle
  task automatic drain();
    in_valid = 1'b0;
    wait (expected_q.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // ---------------- APB access ----------------

  task automatic apb_write(logic [1:0] addr, logic [31:0] data);
    psel = 1'b1; pwrite = 1'b1; paddr = addr; pwdata = data; penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (addr == ADDR_STEP_TIME) step_time_model = data[ST_W-1:0];
  endtask

  task automatic check_step_time();
    psel = 1'b1; pwrite = 1'b0; paddr = ADDR_STEP_TIME; penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(step_time_model)) begin
      fails++;
      if (fails <= 10)
        $display("step_time readback: expected %0d got %0d", step_time_model, prdata);
    end
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
  endtask

  // ---------------- result receiver ----------------

  initial begin
    int stall;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = long_hold ? LONG_HOLD : $urandom_range(0, rx_idle_max);
      long_hold = 1'b0;
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic check_field(string name, vec_t exp_v, vec_t act_v);
    if (exp_v !== act_v) begin
      fails++;
      if (fails <= 10)
        $display("%s mismatch: expected %h got %h", name, exp_v, act_v);
    end
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result transfer");
      end else begin
        e = expected_q.pop_front();
        check_field("new_vel_a", e.nva, out_nva);
        check_field("new_vel_b", e.nvb, out_nvb);
        check_field("new_pos_a", e.npa, out_npa);
        check_field("new_pos_b", e.npb, out_npb);
        check_field("move_a", e.ma, out_ma);
        check_field("move_b", e.mb, out_mb);
      end
    end
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // ---------------- test sequence ----------------

  initial begin
    contact_row_t rows[$];
    contact_row_t row;
    contact_t c;
    logic [ST_W-1:0] st_list[6];
    vec_t vmax, vmin;

    vmax = vec3(1048575, 1048575, 1048575);
    vmin = vec3(-1048576, -1048576, -1048576);

    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    check_step_time();

    // all zero: every output zero
    row.c = '{default: '0};
    row.has_res = 1'b1;
    row.res = '{default: '0};
    rows.push_back(row);
    // infinite masses: inputs pass through, no movement
    row.c = '{va: vmax, vb: vmin, aa: vmin, ab: vmax, pa: vmax, pb: vmin,
              nrm: vec3(4096, 0, 0), ima: '0, imb: '0, pen: 21'sd4096, rest: 13'd4096};
    row.res = '{nva: vmax, nvb: vmin, npa: vmax, npb: vmin, ma: '0, mb: '0};
    rows.push_back(row);
    row.has_res = 1'b0;
    // closing head-on, equal masses, full restitution
    row.c = '{va: vec3(-4096, 0, 0), vb: vec3(4096, 0, 0), aa: '0, ab: '0,
              pa: vec3(100, 200, 300), pb: vec3(-100, 0, 0), nrm: vec3(4096, 0, 0),
              ima: 16'd4096, imb: 16'd4096, pen: 21'sd2048, rest: 13'd4096};
    rows.push_back(row);
    // separating contact
    row.c.va = vec3(4096, 0, 0); row.c.vb = vec3(-4096, 0, 0);
    rows.push_back(row);
    // no penetration
    row.c.va = vec3(-8192, 77, -5); row.c.pen = -21'sd4096;
    rows.push_back(row);
    // absent second particle
    row.c = '{va: vec3(0, -4096, 0), vb: '0, aa: vec3(0, -40000, 0), ab: '0,
              pa: vec3(0, 50, 0), pb: '0, nrm: vec3(0, 4096, 0),
              ima: 16'd4096, imb: '0, pen: 21'sd300, rest: 13'd2048};
    rows.push_back(row);
    // restitution above one, maximal field values
    row.c = '{va: vmin, vb: vmax, aa: vmin, ab: vmax, pa: vmax, pb: vmin, nrm: vmax,
              ima: '1, imb: '1, pen: 21'sd1048575, rest: '1};
    rows.push_back(row);
    row.c = '{va: vmax, vb: vmin, aa: vmax, ab: vmin, pa: vmin, pb: vmax, nrm: vmin,
              ima: '1, imb: 16'd1, pen: -21'sd1048576, rest: '0};
    rows.push_back(row);
    row.c.nrm = vmax; row.c.pen = 21'sd1048575; row.c.ima = 16'd1; row.c.imb = '1;
    rows.push_back(row);
    // acceleration build-up cancelling the bounce
    row.c = '{va: vec3(0, 0, -100), vb: '0, aa: vec3(0, 0, -1048576), ab: '0,
              pa: '0, pb: '0, nrm: vec3(0, 0, 4096), ima: 16'd4096, imb: 16'd0,
              pen: 21'sd0, rest: 13'd4096};
    rows.push_back(row);
    // one bit set everywhere, then every bit
    row.c = '{va: 63'd1, vb: 63'd1, aa: 63'd1, ab: 63'd1, pa: 63'd1, pb: 63'd1,
              nrm: 63'd1, ima: 16'd1, imb: 16'd1, pen: 21'sd1, rest: 13'd1};
    rows.push_back(row);
    row.c = '{va: '1, vb: '1, aa: '1, ab: '1, pa: '1, pb: '1, nrm: '1,
              ima: '1, imb: '1, pen: -21'sd1, rest: '1};
    rows.push_back(row);
    for (int i = 0; i < 8; i++) begin
      row.c = rand_contact();
      rows.push_back(row);
    end

    foreach (rows[i]) begin
      if (rows[i].has_res) send_contact(rows[i].c, rows[i].res);
      else send_predicted(rows[i].c);
    end
    drain();

    // register settings, extremes first; an out-of-range address in between
    st_list = '{16'd0, 16'hFFFF, 16'd68, 16'd1, ST_W'($urandom), ST_W'($urandom)};
    for (int p = 0; p < 6; p++) begin
      apb_write(ADDR_STEP_TIME, {16'($urandom_range(0, 65535)), st_list[p]});
      step_time_model = st_list[p];
      if (p == 2) apb_write(2'd1 + 2'($urandom_range(0, 2)), $urandom);
      check_step_time();
      for (int i = 0; i < 200; i++) begin
        if (i % 40 == 0) begin
          tx_idle_max = $urandom_range(0, 1) ? 6 : 0;
          rx_idle_max = $urandom_range(0, 1) ? 6 : 0;
        end
        // back-pressure burst: receiver holds off while sender streams
        if (p == 1 && i == 100) begin
          tx_idle_max = 0;
          long_hold = 1'b1;
        end
        // sender pause until everything has drained
        if (p == 3 && i == 100) begin
          in_valid = 1'b0;
          wait (expected_q.size() == 0);
          @(negedge clk);
        end
        send_predicted(rand_contact());
      end
      drain();
    end

    if (fails == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
